// ----- src/ascdq_pkg.sv -----
// ----------------------------------------------------------------------------
// ascdq_pkg
// Shared types, codes and tables for the ASCII decimal to Q7.8 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ascdq_pkg;

    localparam int MAX_FRAC_DIGITS_DEF = 6;
    localparam int FRAC_BITS           = 8;
    localparam int POW_W               = 24;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_SYNTAX = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;

    localparam logic [7:0] POS_LIMIT = 8'd127;
    localparam logic [7:0] NEG_LIMIT = 8'd128;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_SIGN  = 3'd1,
        PH_INT   = 3'd2,
        PH_SEP   = 3'd3,
        PH_FRAC  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_IN  = 2'd0,
        ST_DIV = 2'd1,
        ST_OUT = 2'd2
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
        logic [POW_W-1:0] p;
        case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- src/ascdq_div.sv -----
// ----------------------------------------------------------------------------
// ascdq_div
// Restoring divider: one compare-subtract per cycle, eight quotient bits of
// (num * 256) / den, with num known to be below den.
// ----------------------------------------------------------------------------
`default_nettype none

module ascdq_div #(
    parameter int FRAC_W = 20
) (
    input  wire  logic                             i_clk,
    input  wire  logic                             i_rst_n,
    input  wire  logic                             i_start,
    input  wire  logic [FRAC_W-1:0]                i_num,
    input  wire  logic [FRAC_W-1:0]                i_den,
    output logic [ascdq_pkg::FRAC_BITS-1:0]        o_quot,
    output ascdq_pkg::t_div_sts                    o_sts
);

    localparam int CNT_W = $clog2(ascdq_pkg::FRAC_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ascdq_pkg::FRAC_BITS - 1);

    logic [FRAC_W-1:0]                r_rem;
    logic [FRAC_W-1:0]                r_den;
    logic [ascdq_pkg::FRAC_BITS-1:0]  r_quot;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_busy;
    logic                             r_done;
    logic [FRAC_W:0]                  w_shift;
    logic                             w_fit;
    logic [FRAC_W:0]                  w_diff;

    assign w_shift = {r_rem, 1'b0};
    assign w_fit   = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[FRAC_W-1:0] : w_shift[FRAC_W-1:0];
            r_quot <= {r_quot[ascdq_pkg::FRAC_BITS-2:0], w_fit};
        end
    end

    assign o_quot     = r_quot;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

// ----- src/ascii_decimal_to_q7_8.sv -----
// Order: a terminator that ends a valid number starts the divider, and its
//   result is registered when the divider is done; a malformed number gives
//   its result the next cycle.
// Throughput: one character per cycle; no word is taken while the divider
//   runs or a result waits.
// Reset: synchronous, active low; clears the parser and the output valid.
// ----------------------------------------------------------------------------
// ascii_decimal_to_q7_8
// Streaming parser of ASCII decimal numbers giving a Q7.8 value and status.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_decimal_to_q7_8 #(
    parameter int MAX_FRAC_DIGITS = ascdq_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire  logic               i_clk,
    input  wire  logic               i_rst_n,
    input  wire  logic               i_valid,
    output logic                     o_ready,
    input  wire  logic [7:0]         i_char_code,
    output logic                     o_valid,
    input  wire  logic               i_ready,
    output logic signed [15:0]       o_fixed_value,
    output logic [1:0]               o_status
);

    localparam int FRAC_W = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam logic [2:0] MAX_DIG = 3'(MAX_FRAC_DIGITS);

    ascdq_pkg::t_state   r_state, n_state;
    ascdq_pkg::t_phase   r_phase, n_phase;
    logic                r_neg, n_neg;
    logic [7:0]          r_whole, n_whole;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [2:0]          r_digits, n_digits;
    logic                r_bad, n_bad;
    logic [15:0]         r_value, n_value;
    logic [1:0]          r_status, n_status;

    logic                         w_accept;
    logic                         w_digit;
    logic                         w_sep;
    logic [3:0]                   w_d;
    logic [11:0]                  w_wsum;
    logic [FRAC_W+3:0]            w_fsum;
    logic [ascdq_pkg::POW_W-1:0]  w_pow;
    logic                         w_start;
    logic [ascdq_pkg::FRAC_BITS-1:0] w_quot;
    ascdq_pkg::t_div_sts          w_div_sts;
    logic [15:0]                  w_mag;

    assign w_accept = i_valid && o_ready;
    assign w_digit  = (i_char_code >= ascdq_pkg::CH_ZERO) && (i_char_code <= ascdq_pkg::CH_NINE);
    assign w_sep    = (i_char_code == ascdq_pkg::CH_DOT) || (i_char_code == ascdq_pkg::CH_COMMA);
    assign w_d      = i_char_code[3:0];
    assign w_wsum   = {1'b0, r_whole, 3'b000} + {3'b000, r_whole, 1'b0} + {8'd0, w_d};
    assign w_fsum   = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0} + {FRAC_W'(0), w_d};
    assign w_pow    = ascdq_pkg::pow10(r_digits);
    assign w_mag    = {r_whole, w_quot};

    ascdq_div #(
        .FRAC_W (FRAC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_frac),
        .i_den   (w_pow[FRAC_W-1:0]),
        .o_quot  (w_quot),
        .o_sts   (w_div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ascdq_pkg::ST_IN;
            r_phase  <= ascdq_pkg::PH_START;
            r_neg    <= 1'b0;
            r_whole  <= '0;
            r_frac   <= '0;
            r_digits <= '0;
            r_bad    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_whole  <= n_whole;
            r_frac   <= n_frac;
            r_digits <= n_digits;
            r_bad    <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_whole  = r_whole;
        n_frac   = r_frac;
        n_digits = r_digits;
        n_bad    = r_bad;
        n_value  = r_value;
        n_status = r_status;
        w_start  = 1'b0;
        o_ready  = 1'b0;
        o_valid  = 1'b0;

        unique case (r_state)
            ascdq_pkg::ST_IN: begin
                o_ready = 1'b1;
                if (w_accept && (i_char_code == ascdq_pkg::CH_NUL)) begin
                    if (r_bad || !((r_phase == ascdq_pkg::PH_INT) ||
                                   (r_phase == ascdq_pkg::PH_FRAC))) begin
                        n_value  = '0;
                        n_status = ascdq_pkg::STAT_SYNTAX;
                        n_state  = ascdq_pkg::ST_OUT;
                        n_phase  = ascdq_pkg::PH_START;
                        n_neg    = 1'b0;
                        n_whole  = '0;
                        n_frac   = '0;
                        n_digits = '0;
                        n_bad    = 1'b0;
                    end else begin
                        w_start = !w_div_sts.busy;
                        n_state = ascdq_pkg::ST_DIV;
                    end
                end else if (w_accept && !r_bad) begin
                    unique case (r_phase)
                        ascdq_pkg::PH_START, ascdq_pkg::PH_SIGN, ascdq_pkg::PH_INT: begin
                            if ((r_phase == ascdq_pkg::PH_START) &&
                                (i_char_code == ascdq_pkg::CH_MINUS)) begin
                                n_neg   = 1'b1;
                                n_phase = ascdq_pkg::PH_SIGN;
                            end else if (w_digit) begin
                                n_whole = (w_wsum > 12'd255) ? 8'd255 : w_wsum[7:0];
                                n_phase = ascdq_pkg::PH_INT;
                            end else if (w_sep && (r_phase == ascdq_pkg::PH_INT)) begin
                                n_phase = ascdq_pkg::PH_SEP;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end
                        ascdq_pkg::PH_SEP, ascdq_pkg::PH_FRAC: begin
                            if (w_digit && (r_digits < MAX_DIG)) begin
                                n_frac   = w_fsum[FRAC_W-1:0];
                                n_digits = r_digits + 3'd1;
                                n_phase  = ascdq_pkg::PH_FRAC;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end
                        default: n_bad = 1'b1;
                    endcase
                end
            end
            ascdq_pkg::ST_DIV: begin
                if (w_div_sts.done) begin
                    if ((!r_neg && (r_whole > ascdq_pkg::POS_LIMIT)) ||
                        (r_neg && (r_whole > ascdq_pkg::NEG_LIMIT)) ||
                        (r_neg && (r_whole == ascdq_pkg::NEG_LIMIT) && (w_quot != '0))) begin
                        n_value  = '0;
                        n_status = ascdq_pkg::STAT_RANGE;
                    end else begin
                        n_value  = r_neg ? (16'd0 - w_mag) : w_mag;
                        n_status = ascdq_pkg::STAT_OK;
                    end
                    n_state  = ascdq_pkg::ST_OUT;
                    n_phase  = ascdq_pkg::PH_START;
                    n_neg    = 1'b0;
                    n_whole  = '0;
                    n_frac   = '0;
                    n_digits = '0;
                    n_bad    = 1'b0;
                end
            end
            ascdq_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ascdq_pkg::ST_IN;
                end
            end
            default: n_state = ascdq_pkg::ST_IN;
        endcase
    end

    assign o_fixed_value = r_value;
    assign o_status      = r_status;

endmodule

`default_nettype wire

// ----- src/ascdq_chk.sv -----
// ----------------------------------------------------------------------------
// ascdq_chk
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ascdq_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic [7:0]         i_char_code,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic signed [15:0] o_fixed_value,
    input wire logic [1:0]         o_status
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fixed_value) && $stable(o_status))
        else $error("stalled result word changed");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result waits");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ascdq_pkg::STAT_OK) |->
            (o_fixed_value == 16'sd0) &&
            ((o_status == ascdq_pkg::STAT_SYNTAX) || (o_status == ascdq_pkg::STAT_RANGE)))
        else $error("failed result word carries a value");

    a_char_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_char_code != ascdq_pkg::CH_NUL) |=> !o_valid)
        else $error("character word produced a result");

endmodule

bind ascii_decimal_to_q7_8 ascdq_chk u_ascdq_chk (.*);

`default_nettype wire
